// ----- rtl/max_pool2d_int16_stream_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the max pooling unit
// Concurrent assertion helpers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL2D_INT16_STREAM_UNIT_ASSERT_SVH
`define MAX_POOL2D_INT16_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MP2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define MP2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MP2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MP2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/mp2d_pkg.sv -----
// ----------------------------------------------------------------------------
// Max pooling package
// Shared widths, register indexes and the window position record.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LINE_DEPTH = 1024;
    localparam int LINE_AW    = 10;
    localparam int MAX_POOL   = 8;
    localparam int WIN_W      = 3;

    localparam int POOL_W = 4;
    localparam int CH_W   = 11;
    localparam int IH_W   = 13;
    localparam int IW_W   = 11;
    localparam int OH_W   = 13;
    localparam int OW_W   = 11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd5;

    // Where the current sample sits relative to its pooling window.
    typedef struct packed {
        logic               active;
        logic               first_col;
        logic               last_col;
        logic               first_row;
        logic               last_row;
        logic               frame_last;
        logic [LINE_AW-1:0] addr;
    } t_pos;

endpackage

// ----- rtl/mp2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// Max pooling raster control
// Holds the configuration registers and the raster and window counters, and
// reports the window position of the next sample to be accepted.
// ----------------------------------------------------------------------------
module mp2d_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_step,
    output mp2d_pkg::t_pos                   o_pos
);
    import mp2d_pkg::*;

    logic [POOL_W-1:0] r_pool_size;
    logic [CH_W-1:0]   r_channels;
    logic [IH_W-1:0]   r_in_height;
    logic [IW_W-1:0]   r_in_width;
    logic [OH_W-1:0]   r_out_height;
    logic [OW_W-1:0]   r_out_width;

    logic [IW_W-1:0]   r_col_count, n_col_count;
    logic [IH_W-1:0]   r_row_count, n_row_count;
    logic [CH_W-1:0]   r_chan_count, n_chan_count;
    logic [WIN_W-1:0]  r_win_col, n_win_col;
    logic [WIN_W-1:0]  r_win_row, n_win_row;
    logic [OW_W-1:0]   r_out_col, n_out_col;
    logic [OH_W-1:0]   r_out_row, n_out_row;

    logic [WIN_W-1:0]  w_p_m1;
    logic [CH_W-1:0]   w_ch_m1;
    logic [IH_W-1:0]   w_ih_m1;
    logic [IW_W-1:0]   w_iw_m1;
    logic [OH_W-1:0]   w_oh;
    logic [OW_W-1:0]   w_ow;

    // Effective sizes: zero acts as one, the window and output width clamp.
    always_comb begin
        if (r_pool_size == '0) begin
            w_p_m1 = '0;
        end else if (r_pool_size > POOL_W'(MAX_POOL)) begin
            w_p_m1 = WIN_W'(MAX_POOL - 1);
        end else begin
            w_p_m1 = WIN_W'(r_pool_size - POOL_W'(1));
        end
        w_ch_m1 = (r_channels == '0) ? '0 : r_channels - CH_W'(1);
        w_ih_m1 = (r_in_height == '0) ? '0 : r_in_height - IH_W'(1);
        w_iw_m1 = (r_in_width == '0) ? '0 : r_in_width - IW_W'(1);
        w_oh    = (r_out_height == '0) ? OH_W'(1) : r_out_height;
        if (r_out_width == '0) begin
            w_ow = OW_W'(1);
        end else if (r_out_width > OW_W'(LINE_DEPTH)) begin
            w_ow = OW_W'(LINE_DEPTH);
        end else begin
            w_ow = r_out_width;
        end
    end

    always_comb begin
        o_pos.active     = (r_out_col < w_ow) && (r_out_row < w_oh);
        o_pos.first_col  = (r_win_col == '0);
        o_pos.last_col   = (r_win_col >= w_p_m1);
        o_pos.first_row  = (r_win_row == '0);
        o_pos.last_row   = (r_win_row >= w_p_m1);
        o_pos.frame_last = (r_out_col == w_ow - OW_W'(1)) &&
                           (r_out_row == w_oh - OH_W'(1)) &&
                           (r_chan_count >= w_ch_m1);
        o_pos.addr       = r_out_col[LINE_AW-1:0];
    end

    always_comb begin
        n_col_count  = r_col_count;
        n_row_count  = r_row_count;
        n_chan_count = r_chan_count;
        n_win_col    = r_win_col;
        n_win_row    = r_win_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        if (r_col_count >= w_iw_m1) begin
            n_col_count = '0;
            n_win_col   = '0;
            n_out_col   = '0;
            if (r_row_count >= w_ih_m1) begin
                n_row_count  = '0;
                n_win_row    = '0;
                n_out_row    = '0;
                n_chan_count = (r_chan_count >= w_ch_m1) ? '0 : r_chan_count + CH_W'(1);
            end else begin
                n_row_count = r_row_count + IH_W'(1);
                if (r_win_row >= w_p_m1) begin
                    n_win_row = '0;
                    n_out_row = r_out_row + OH_W'(1);
                end else begin
                    n_win_row = r_win_row + WIN_W'(1);
                end
            end
        end else begin
            n_col_count = r_col_count + IW_W'(1);
            if (r_win_col >= w_p_m1) begin
                n_win_col = '0;
                n_out_col = r_out_col + OW_W'(1);
            end else begin
                n_win_col = r_win_col + WIN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size  <= POOL_W'(2);
            r_channels   <= CH_W'(1);
            r_in_height  <= IH_W'(32);
            r_in_width   <= IW_W'(32);
            r_out_height <= OH_W'(16);
            r_out_width  <= OW_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POOL_SIZE:  r_pool_size  <= i_cfg_data[POOL_W-1:0];
                REG_CHANNELS:   r_channels   <= i_cfg_data[CH_W-1:0];
                REG_IN_HEIGHT:  r_in_height  <= i_cfg_data[IH_W-1:0];
                REG_IN_WIDTH:   r_in_width   <= i_cfg_data[IW_W-1:0];
                REG_OUT_HEIGHT: r_out_height <= i_cfg_data[OH_W-1:0];
                REG_OUT_WIDTH:  r_out_width  <= i_cfg_data[OW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count  <= '0;
            r_row_count  <= '0;
            r_chan_count <= '0;
            r_win_col    <= '0;
            r_win_row    <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
        end else if (i_step) begin
            r_col_count  <= n_col_count;
            r_row_count  <= n_row_count;
            r_chan_count <= n_chan_count;
            r_win_col    <= n_win_col;
            r_win_row    <= n_win_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
        end
    end

endmodule

// ----- rtl/max_pool2d_int16_stream_unit.sv -----
// The sample beat that closes a window is registered in the working stage, then its result beat in the output register.
// Throughput: one sample beat per cycle while the output side keeps taking beats.
// The line store has one write and one read port; a one-entry bypass covers back-to-back use.
// Reset clears the counters and the running maximum and loads the default configuration.
// The line store is not cleared; every entry is written before it is read in a frame.
// ----------------------------------------------------------------------------
// Streaming 2-D max pooling unit
// Pools signed 16-bit samples over square windows with a per-column line store.
// ----------------------------------------------------------------------------
`include "max_pool2d_int16_stream_unit_assert.svh"

module max_pool2d_int16_stream_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mp2d_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mp2d_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [15:0] pooled_value
    output logic                             m_axis_tlast    // frame_last
);
    import mp2d_pkg::*;

    t_pos                       w_pos;
    logic                       w_acc;
    logic                       w_adv;
    logic                       w_wr;
    logic                       w_load;

    logic                       r_s1_v;
    t_pos                       r_s1_pos;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SAMPLE_W-1:0] r_run_max;

    logic                       r_fw_v;
    logic [LINE_AW-1:0]         r_fw_addr;
    logic signed [SAMPLE_W-1:0] r_fw_data;

    logic                       r_o_v;
    logic [SAMPLE_W-1:0]        r_o_data;
    logic                       r_o_last;

    logic signed [SAMPLE_W-1:0] w_line_old;
    logic signed [SAMPLE_W-1:0] w_run_new;
    logic signed [SAMPLE_W-1:0] w_line_new;

    logic signed [SAMPLE_W-1:0] r_line_mem [LINE_DEPTH];

    mp2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_acc),
        .o_pos      (w_pos)
    );

    assign w_adv         = r_s1_v && (!r_o_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // The read for a sample can race the write of the sample before it; the last
    // write is held so that the newest value for that column wins.
    assign w_line_old = (r_fw_v && (r_fw_addr == r_s1_pos.addr)) ? r_fw_data : r_rd_data;
    assign w_run_new  = (r_s1_pos.first_col || (r_s1_sample > r_run_max)) ?
                        r_s1_sample : r_run_max;
    assign w_line_new = (r_s1_pos.first_row || (w_run_new > w_line_old)) ?
                        w_run_new : w_line_old;
    assign w_wr       = w_adv && r_s1_pos.active && r_s1_pos.last_col;
    assign w_load     = w_wr && r_s1_pos.last_row;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_data <= r_line_mem[w_pos.addr];
        end
        if (w_wr) begin
            r_line_mem[r_s1_pos.addr] <= w_line_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_pos    <= w_pos;
            r_s1_sample <= s_axis_tdata;
        end
        if (w_wr) begin
            r_fw_addr <= r_s1_pos.addr;
            r_fw_data <= w_line_new;
        end
        if (w_load) begin
            r_o_data <= w_line_new;
            r_o_last <= r_s1_pos.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_fw_v    <= 1'b0;
            r_o_v     <= 1'b0;
            r_run_max <= '0;
        end else begin
            if (w_acc) begin
                r_s1_v <= 1'b1;
            end else if (w_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_wr) begin
                r_fw_v <= 1'b1;
            end
            if (w_load) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
            if (w_adv && r_s1_pos.active) begin
                r_run_max <= w_run_new;
            end
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    // A pooled result never falls below the sample that closed its window.
    `MP2D_ASSERT_NXT(a_result_ge_sample, i_clk, i_rst_n, w_load, $signed(m_axis_tdata) >= $signed($past(r_s1_sample)), "pooled value below closing sample")
    // A held sample in the working stage is neither lost nor altered.
    `MP2D_ASSERT_NXT(a_stage_holds, i_clk, i_rst_n, r_s1_v && !w_adv, r_s1_v && $stable(r_s1_sample) && $stable(r_s1_pos), "working stage dropped a held sample")
    // The bypass register always mirrors the most recent line store write.
    `MP2D_ASSERT_NXT(a_bypass_tracks, i_clk, i_rst_n, w_wr, r_fw_v && r_fw_addr == $past(r_s1_pos.addr) && r_fw_data == $past(w_line_new), "bypass out of step with line store")
    // A result is only produced while the output register can take it.
    `MP2D_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, w_load, !r_o_v || m_axis_tready, "result overwrote a pending beat")

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the streaming 2-D max pooling unit
// Drives signed samples and register writes into the unit. A behavioral
// predictor tracks the raster position and the window maxima, and every
// pooled beat is checked in order against it. Both stream sides stall at
// random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mp2d_pkg::*;

    typedef struct packed {
        logic [mp2d_pkg::SAMPLE_W-1:0] value;
        logic                          last;
    } t_pooled_beat;

    class window_max_tracker;
        logic [mp2d_pkg::POOL_W-1:0] pool_r;
        logic [mp2d_pkg::CH_W-1:0]   chan_r;
        logic [mp2d_pkg::IH_W-1:0]   in_h_r;
        logic [mp2d_pkg::IW_W-1:0]   in_w_r;
        logic [mp2d_pkg::OH_W-1:0]   out_h_r;
        logic [mp2d_pkg::OW_W-1:0]   out_w_r;

        logic signed [mp2d_pkg::SAMPLE_W-1:0] col_peak [mp2d_pkg::LINE_DEPTH];
        logic signed [mp2d_pkg::SAMPLE_W-1:0] row_peak;
        int unsigned col_pos, row_pos, chan_pos;
        int unsigned win_x, win_y, out_x, out_y;

        t_pooled_beat pooled_due [$];
        int errors;

        function new();
            pool_r  = mp2d_pkg::POOL_W'(2);
            chan_r  = mp2d_pkg::CH_W'(1);
            in_h_r  = mp2d_pkg::IH_W'(32);
            in_w_r  = mp2d_pkg::IW_W'(32);
            out_h_r = mp2d_pkg::OH_W'(16);
            out_w_r = mp2d_pkg::OW_W'(16);
            foreach (col_peak[k]) col_peak[k] = '0;
            row_peak = '0;
            col_pos  = 0;
            row_pos  = 0;
            chan_pos = 0;
            win_x    = 0;
            win_y    = 0;
            out_x    = 0;
            out_y    = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [mp2d_pkg::CFG_IDX_W-1:0] idx,
                              logic [mp2d_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mp2d_pkg::REG_POOL_SIZE:  pool_r  = data[mp2d_pkg::POOL_W-1:0];
                mp2d_pkg::REG_CHANNELS:   chan_r  = data[mp2d_pkg::CH_W-1:0];
                mp2d_pkg::REG_IN_HEIGHT:  in_h_r  = data[mp2d_pkg::IH_W-1:0];
                mp2d_pkg::REG_IN_WIDTH:   in_w_r  = data[mp2d_pkg::IW_W-1:0];
                mp2d_pkg::REG_OUT_HEIGHT: out_h_r = data[mp2d_pkg::OH_W-1:0];
                mp2d_pkg::REG_OUT_WIDTH:  out_w_r = data[mp2d_pkg::OW_W-1:0];
                default: ;
            endcase
        endfunction

        static function int unsigned at_least_one(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function void take_sample(logic [mp2d_pkg::SAMPLE_W-1:0] raw);
            int unsigned p, ch, ih, iw, oh, ow;
            logic signed [mp2d_pkg::SAMPLE_W-1:0] s;
            t_pooled_beat beat;
            p  = at_least_one(pool_r);
            ch = at_least_one(chan_r);
            ih = at_least_one(in_h_r);
            iw = at_least_one(in_w_r);
            oh = at_least_one(out_h_r);
            ow = at_least_one(out_w_r);
            if (p > mp2d_pkg::MAX_POOL) p = mp2d_pkg::MAX_POOL;
            if (ow > mp2d_pkg::LINE_DEPTH) ow = mp2d_pkg::LINE_DEPTH;
            s = raw;

            if (out_x < ow && out_y < oh) begin
                if (win_x == 0 || s > row_peak) row_peak = s;
                if (win_x >= p - 1) begin
                    if (win_y == 0 || row_peak > col_peak[out_x]) col_peak[out_x] = row_peak;
                    if (win_y >= p - 1) begin
                        beat.value = col_peak[out_x];
                        beat.last  = (out_x == ow - 1 && out_y == oh - 1 && chan_pos >= ch - 1);
                        pooled_due.push_back(beat);
                    end
                end
            end

            // Counters that sit at or past their bound wrap on this sample.
            if (col_pos >= iw - 1) begin
                col_pos = 0;
                win_x   = 0;
                out_x   = 0;
                if (row_pos >= ih - 1) begin
                    row_pos  = 0;
                    win_y    = 0;
                    out_y    = 0;
                    chan_pos = (chan_pos >= ch - 1) ? 0 : chan_pos + 1;
                end else begin
                    row_pos++;
                    if (win_y >= p - 1) begin
                        win_y = 0;
                        out_y++;
                    end else begin
                        win_y++;
                    end
                end
            end else begin
                col_pos++;
                if (win_x >= p - 1) begin
                    win_x = 0;
                    out_x++;
                end else begin
                    win_x++;
                end
            end
        endfunction

        function void check_pooled(logic [mp2d_pkg::SAMPLE_W-1:0] value, logic last);
            t_pooled_beat want;
            if (pooled_due.size() == 0) begin
                if (errors < 40)
                    $display("%0t: unexpected pooled beat, value %0d last %0b",
                             $time, $signed(value), last);
                errors++;
                return;
            end
            want = pooled_due.pop_front();
            if (value !== want.value) begin
                if (errors < 40)
                    $display("%0t: pooled value expected %0d, got %0d",
                             $time, $signed(want.value), $signed(value));
                errors++;
            end
            if (last !== want.last) begin
                if (errors < 40)
                    $display("%0t: frame last expected %0b, got %0b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pooled_due.size();
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int SAMPLE_TARGET = 1320;
    localparam int QUIET_MARGIN  = 120;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [SAMPLE_W-1:0]   m_axis_tdata;   // [15:0] pooled_value
    logic                  m_axis_tlast;   // frame_last

    window_max_tracker track;
    bit                quiet = 1'b0;
    bit                long_hold = 1'b0;
    int unsigned       sent = 0;
    int unsigned       stall_count = 0;

    always #2 i_clk = ~i_clk;

    max_pool2d_int16_stream_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Writes all six registers; with scramble set, bits above each register's
    // width are filled at random and one spare index is written as well.
    task automatic load_config(input int unsigned pool, ch, ih, iw, oh, ow,
                               input bit scramble);
        logic [CFG_DATA_W-1:0] word [6];
        logic [CFG_IDX_W-1:0]  index [6];
        int unsigned           bits [6];
        word[0]  = CFG_DATA_W'(pool);   word[1]  = CFG_DATA_W'(ch);
        word[2]  = CFG_DATA_W'(ih);     word[3]  = CFG_DATA_W'(iw);
        word[4]  = CFG_DATA_W'(oh);     word[5]  = CFG_DATA_W'(ow);
        index[0] = REG_POOL_SIZE;   index[1] = REG_CHANNELS;   index[2] = REG_IN_HEIGHT;
        index[3] = REG_IN_WIDTH;    index[4] = REG_OUT_HEIGHT; index[5] = REG_OUT_WIDTH;
        bits[0]  = POOL_W;          bits[1]  = CH_W;           bits[2]  = IH_W;
        bits[3]  = IW_W;            bits[4]  = OH_W;           bits[5]  = OW_W;
        for (int k = 0; k < 6; k++) begin
            if (scramble && bits[k] < CFG_DATA_W)
                word[k] = word[k] | CFG_DATA_W'($urandom() << bits[k]);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= index[k];
            i_cfg_data <= word[k];
            @(posedge i_clk);
            track.set_reg(index[k], word[k]);
        end
        if (scramble) begin
            i_cfg_idx  <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
            i_cfg_data <= CFG_DATA_W'($urandom());
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        track.take_sample(value);
        sent++;
    endtask

    // Samples outside any emitted window may still be in flight after the
    // last pooled beat, so the unit is left to settle before any write.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (track.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            track.check_pooled(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        int unsigned pool_raw, pe, ch, ih, iw, oh, ow, len;
        track = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_POOL_SIZE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All dimensions zero act as one, so every sample closes a frame.
        load_config(0, 0, 0, 0, 0, 0, 1'b1);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'hffff);
        finish_phase();

        // Two 2x2 windows on a 2x5 map; the fifth column is dropped.
        load_config(2, 1, 2, 5, 1, 2, 1'b0);
        send_sample(16'hfffb); send_sample(16'h0003); send_sample(16'h7fff);
        send_sample(16'h8000); send_sample(16'h0009);
        send_sample(16'h8000); send_sample(16'h8000); send_sample(16'hffff);
        send_sample(16'h0000); send_sample(16'h0064);
        finish_phase();

        // Pooled area larger than the input: the frame's last window never comes.
        load_config(1, 2, 1, 3, 2, 4, 1'b0);
        repeat (6) send_sample(pick_sample());
        finish_phase();

        // One full-width row writes every line store entry, so later
        // mid-frame register changes never read an unwritten entry.
        load_config(1, 1, 1, LINE_DEPTH, 1, 2047, 1'b0);
        long_hold = 1'b1;
        repeat (LINE_DEPTH) send_sample(pick_sample());
        finish_phase();

        // Large settings with the pool size above its clamp; the frame is left unfinished on purpose.
        load_config(15, 1024, 4096, 17, 4096, 2, 1'b0);
        repeat (MAX_POOL * 17) send_sample(pick_sample());
        finish_phase();

        while (sent < SAMPLE_TARGET) begin
            case ($urandom_range(0, 9))
                0: pool_raw = 0;
                1: pool_raw = $urandom_range(MAX_POOL + 1, 15);
                2, 3: pool_raw = $urandom_range(5, MAX_POOL);
                default: pool_raw = $urandom_range(1, 4);
            endcase
            pe = (pool_raw == 0) ? 1 : (pool_raw > MAX_POOL) ? MAX_POOL : pool_raw;
            ow = (pe > 4) ? 1 : $urandom_range(1, 3);
            oh = (pe > 4) ? 1 : $urandom_range(1, 3);
            iw = pe * ow + $urandom_range(0, 2);
            ih = pe * oh + $urandom_range(0, 2);
            ch = $urandom_range(1, 2);
            case ($urandom_range(0, 7))
                0: ow = ow + 1;
                1: oh = oh + 1;
                2: ch = 0;
                default: ;
            endcase
            len = ((ch == 0) ? 1 : ch) * ih * iw;
            if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
            if (sent + QUIET_MARGIN >= SAMPLE_TARGET) quiet = 1'b1;
            load_config(pool_raw, ch, ih, iw, oh, ow, $urandom_range(0, 3) == 0);
            repeat (len) send_sample(pick_sample());
            finish_phase();
        end

        if (track.errors == 0 && track.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
